[rtl/core/trapezoidal_pulse_shaper_core_macros.svh]
// Assertion macros of the trapezoidal pulse shaper checker.
`ifndef TRAPEZOIDAL_PULSE_SHAPER_CORE_MACROS_SVH
`define TRAPEZOIDAL_PULSE_SHAPER_CORE_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define TPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tps: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define TPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tps: next-cycle check failed");

`endif

[rtl/core/tps_pkg.sv]
// Shared constants, types and codes of the trapezoidal pulse shaper.
package tps_pkg;

  // Sizing defaults
  localparam int unsigned HISTORY_DEPTH = 2048;
  localparam int unsigned MAX_RISE      = 512;
  localparam int unsigned SAMPLE_BITS   = 17;

  // Register and result field widths
  localparam int unsigned DECAY_W   = 16;
  localparam int unsigned RISE_W    = 10;
  localparam int unsigned FLAT_W    = 11;
  localparam int unsigned GAIN_W    = 25;
  localparam int unsigned SHAPED_W  = 32;
  localparam int unsigned INNER_W   = 32;
  localparam int unsigned OUTER_W   = 48;
  localparam int unsigned GAIN_FRAC = 24;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 25;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DECAY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RISE  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FLAT  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAIN  = CFG_IDX_W'(3);

  // Register reset values
  localparam logic [DECAY_W-1:0] DECAY_RST = DECAY_W'(1000);
  localparam logic [RISE_W-1:0]  RISE_RST  = RISE_W'(100);
  localparam logic [FLAT_W-1:0]  FLAT_RST  = FLAT_W'(100);
  localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(168);

  // Sequencer phases, one item walks through all of them
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TAP_K,
    ST_TAP_L,
    ST_TAP_KL,
    ST_DIFF,
    ST_MUL_MD,
    ST_OUTER,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_FINAL
  } tps_state_e;

  // Source of a delayed tap value
  typedef enum logic [1:0] {
    TAP_ZERO,
    TAP_CUR,
    TAP_MEM
  } tps_tap_e;

  // Sequencer to datapath control
  typedef struct packed {
    tps_state_e state;
    tps_tap_e   tap_code;
    logic       accept;
    logic       first_sample;
  } tps_ctrl_t;

endpackage

[rtl/core/tps_if.sv]
// Request channel interfaces of the trapezoidal pulse shaper.
interface tps_in_if #(
  parameter int unsigned SampleBits = tps_pkg::SAMPLE_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample;
  logic                         first_sample;

  modport source (output valid, output sample, output first_sample, input ready);
  modport sink   (input valid, input sample, input first_sample, output ready);
endinterface

interface tps_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tps_pkg::SHAPED_W-1:0] shaped;

  modport source (output valid, output shaped, input ready);
  modport sink   (input valid, input shaped, output ready);
endinterface

interface tps_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tps_pkg::CFG_IDX_W-1:0]  index;
  logic [tps_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/tps_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tps_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write on request, read old contents in the next cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/tps_seq.sv]
// Sequencer: phase FSM, history write pointer, sample count and tap addressing.
module tps_seq #(
  parameter int unsigned HistoryDepth = tps_pkg::HISTORY_DEPTH,
  parameter int unsigned MaxRise      = tps_pkg::MAX_RISE,
  localparam int unsigned AddrW = $clog2(HistoryDepth),
  localparam int unsigned CntW  = $clog2(HistoryDepth + 1),
  localparam int unsigned DlyW  = (CntW > 13) ? CntW : 13
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_first_i,
  input  logic                        out_free_i,
  input  logic [tps_pkg::RISE_W-1:0] rise_i,
  input  logic [tps_pkg::FLAT_W-1:0] flat_i,
  output logic                        in_ready_o,
  output tps_pkg::tps_ctrl_t          ctrl_o,
  output logic                        ram_we_o,
  output logic [AddrW-1:0]            ram_waddr_o,
  output logic [AddrW-1:0]            ram_raddr_o
);

  tps_pkg::tps_state_e state_q, state_d;
  tps_pkg::tps_tap_e   code_q, code_d;
  logic [AddrW-1:0]    wr_idx_q, wr_idx_d;
  logic [CntW-1:0]     seen_q, seen_d;
  logic                accept;
  logic [DlyW-1:0]     rise_k, len_l, delay;
  logic [AddrW+1:0]    addr_raw, addr_wrap;

  assign accept = (state_q == tps_pkg::ST_IDLE) && in_valid_i;

  // Wait in idle for a request, advance through the phases, hold in the final phase until the result slot frees
  always_comb begin
    state_d = state_q;
    case (state_q)
      tps_pkg::ST_IDLE:   if (in_valid_i) state_d = tps_pkg::ST_TAP_K;
      tps_pkg::ST_TAP_K:  state_d = tps_pkg::ST_TAP_L;
      tps_pkg::ST_TAP_L:  state_d = tps_pkg::ST_TAP_KL;
      tps_pkg::ST_TAP_KL: state_d = tps_pkg::ST_DIFF;
      tps_pkg::ST_DIFF:   state_d = tps_pkg::ST_MUL_MD;
      tps_pkg::ST_MUL_MD: state_d = tps_pkg::ST_OUTER;
      tps_pkg::ST_OUTER:  state_d = tps_pkg::ST_MUL_LO;
      tps_pkg::ST_MUL_LO: state_d = tps_pkg::ST_MUL_HI;
      tps_pkg::ST_MUL_HI: state_d = tps_pkg::ST_FINAL;
      tps_pkg::ST_FINAL:  if (out_free_i) state_d = tps_pkg::ST_IDLE;
      default:            state_d = tps_pkg::ST_IDLE;
    endcase
  end

  // Pick the tap delay of the current read phase, rise clamped to its limit
  always_comb begin
    rise_k = (DlyW'(rise_i) > DlyW'(MaxRise)) ? DlyW'(MaxRise) : DlyW'(rise_i);
    len_l  = rise_k + DlyW'(flat_i);
    case (state_q)
      tps_pkg::ST_TAP_K:  delay = rise_k;
      tps_pkg::ST_TAP_L:  delay = len_l;
      tps_pkg::ST_TAP_KL: delay = rise_k + len_l;
      default:            delay = '0;
    endcase
  end

  // Classify the tap: zero delay is the current sample, anything older than
  // the waveform (or the history, since the count saturates at its depth) is zero
  always_comb begin
    if (delay == '0) begin
      code_d = tps_pkg::TAP_CUR;
    end else if (delay > DlyW'(seen_q)) begin
      code_d = tps_pkg::TAP_ZERO;
    end else begin
      code_d = tps_pkg::TAP_MEM;
    end
  end

  // Form the circular read address, one compare and subtract for the wrap
  always_comb begin
    addr_raw = (AddrW+2)'(wr_idx_q) + (AddrW+2)'(HistoryDepth) - (AddrW+2)'(delay);
    if (addr_raw >= (AddrW+2)'(HistoryDepth)) begin
      addr_wrap = addr_raw - (AddrW+2)'(HistoryDepth);
    end else begin
      addr_wrap = addr_raw;
    end
  end

  // Restart on a waveform start, advance after the sample is stored
  always_comb begin
    wr_idx_d = wr_idx_q;
    seen_d   = seen_q;
    if (accept && in_first_i) begin
      wr_idx_d = '0;
      seen_d   = '0;
    end else if (state_q == tps_pkg::ST_DIFF) begin
      wr_idx_d = (wr_idx_q == AddrW'(HistoryDepth - 1)) ? '0 : wr_idx_q + 1'b1;
      if (seen_q < CntW'(HistoryDepth)) begin
        seen_d = seen_q + 1'b1;
      end
    end
  end

  // Drive handshake, memory and datapath control from the phase
  always_comb begin
    in_ready_o          = (state_q == tps_pkg::ST_IDLE);
    ram_we_o            = (state_q == tps_pkg::ST_DIFF);
    ram_waddr_o         = wr_idx_q;
    ram_raddr_o         = addr_wrap[AddrW-1:0];
    ctrl_o.state        = state_q;
    ctrl_o.tap_code     = code_q;
    ctrl_o.accept       = accept;
    ctrl_o.first_sample = in_first_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tps_pkg::ST_IDLE;
      code_q   <= tps_pkg::TAP_ZERO;
      wr_idx_q <= '0;
      seen_q   <= '0;
    end else begin
      state_q  <= state_d;
      code_q   <= code_d;
      wr_idx_q <= wr_idx_d;
      seen_q   <= seen_d;
    end
  end

endmodule

[rtl/core/tps_datapath.sv]
// Datapath: tap capture, difference, both sums, shared multiplier, gain and saturation.
module tps_datapath #(
  parameter int unsigned SampleBits = tps_pkg::SAMPLE_BITS,
  localparam int unsigned DiffW = SampleBits + 2,
  // Wide enough for the difference and for the zero-extended gain
  localparam int unsigned MulW  = (DiffW > tps_pkg::GAIN_W + 1) ? DiffW : tps_pkg::GAIN_W + 1,
  localparam int unsigned ProdW = 2 * MulW
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  tps_pkg::tps_ctrl_t                   ctrl_i,
  input  logic signed [SampleBits-1:0]         in_sample_i,
  input  logic [SampleBits-1:0]                ram_rdata_i,
  input  logic [tps_pkg::DECAY_W-1:0]         decay_i,
  input  logic [tps_pkg::GAIN_W-1:0]          gain_i,
  input  logic                                 out_ready_i,
  output logic [SampleBits-1:0]                ram_wdata_o,
  output logic                                 out_valid_o,
  output logic signed [tps_pkg::SHAPED_W-1:0] out_shaped_o,
  output logic                                 out_free_o
);

  localparam int unsigned ShW = tps_pkg::SHAPED_W;

  logic signed [SampleBits-1:0]         x_q, tk_q, tl_q, tap_val;
  logic signed [DiffW-1:0]              d_q, d_d;
  logic signed [tps_pkg::INNER_W-1:0]  inner_q;
  logic signed [tps_pkg::OUTER_W-1:0]  outer_q;
  logic signed [MulW-1:0]               mul_a, mul_b;
  logic signed [ProdW-1:0]              prod_q, res;
  logic [tps_pkg::GAIN_W-1:0]          frac_q;
  logic signed [ShW-1:0]                shaped_q, sat;
  logic                                 out_valid_q, ovf;

  // Select the tap value of this cycle: memory read data, the current sample or zero
  always_comb begin
    case (ctrl_i.tap_code)
      tps_pkg::TAP_MEM: tap_val = $signed(ram_rdata_i);
      tps_pkg::TAP_CUR: tap_val = x_q;
      default:          tap_val = '0;
    endcase
  end

  assign d_d = DiffW'(x_q) - DiffW'(tk_q) - DiffW'(tl_q) + DiffW'(tap_val);

  // Share one multiplier: M*d, then the low and high halves of outer*gain
  always_comb begin
    case (ctrl_i.state)
      tps_pkg::ST_MUL_LO: begin
        mul_a = MulW'($signed({1'b0, outer_q[tps_pkg::GAIN_FRAC-1:0]}));
        mul_b = MulW'($signed({1'b0, gain_i}));
      end
      tps_pkg::ST_MUL_HI: begin
        mul_a = MulW'($signed(outer_q[tps_pkg::OUTER_W-1:tps_pkg::GAIN_FRAC]));
        mul_b = MulW'($signed({1'b0, gain_i}));
      end
      default: begin
        mul_a = MulW'($signed({1'b0, decay_i}));
        mul_b = MulW'(d_q);
      end
    endcase
  end

  // Recombine the halves: floor(outer*gain / 2^24), then clamp to 32 bits
  always_comb begin
    res = prod_q + ProdW'($signed({1'b0, frac_q}));
    ovf = !((&res[ProdW-1:ShW-1]) || (~|res[ProdW-1:ShW-1]));
    if (ovf) begin
      sat = res[ProdW-1] ? {1'b1, {(ShW-1){1'b0}}} : {1'b0, {(ShW-1){1'b1}}};
    end else begin
      sat = res[ShW-1:0];
    end
  end

  // Hold sample, taps, difference, products and the shaped result
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      x_q <= in_sample_i;
    end
    case (ctrl_i.state)
      tps_pkg::ST_TAP_L:  tk_q <= tap_val;
      tps_pkg::ST_TAP_KL: tl_q <= tap_val;
      tps_pkg::ST_DIFF:   d_q  <= d_d;
      tps_pkg::ST_MUL_MD: prod_q <= ProdW'(mul_a) * ProdW'(mul_b);
      tps_pkg::ST_MUL_LO: prod_q <= ProdW'(mul_a) * ProdW'(mul_b);
      tps_pkg::ST_MUL_HI: begin
        frac_q <= prod_q[tps_pkg::GAIN_FRAC+tps_pkg::GAIN_W-1:tps_pkg::GAIN_FRAC];
        prod_q <= ProdW'(mul_a) * ProdW'(mul_b);
      end
      default: ;
    endcase
    if ((ctrl_i.state == tps_pkg::ST_FINAL) && out_free_o) begin
      shaped_q <= sat;
    end
  end

  // Clear sums on a waveform start, accumulate once per item, drive result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q     <= '0;
      outer_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.accept && ctrl_i.first_sample) begin
        inner_q <= '0;
        outer_q <= '0;
      end else if (ctrl_i.state == tps_pkg::ST_MUL_MD) begin
        inner_q <= inner_q + tps_pkg::INNER_W'(d_q);
      end else if (ctrl_i.state == tps_pkg::ST_OUTER) begin
        outer_q <= outer_q + tps_pkg::OUTER_W'(inner_q)
                   + $signed(prod_q[tps_pkg::OUTER_W-1:0]);
      end
      if ((ctrl_i.state == tps_pkg::ST_FINAL) && out_free_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_free_o   = !out_valid_q || out_ready_i;
  assign out_valid_o  = out_valid_q;
  assign out_shaped_o = shaped_q;
  assign ram_wdata_o  = x_q;

endmodule

[rtl/core/trapezoidal_pulse_shaper_core.sv]
// An item walks the phases from TAP_K to FINAL and holds in FINAL until the output
// register is free. A new sample is taken only in idle, as the three tap reads share
// the single read port of the history RAM and three passes share the multiplier.
// A finished result waits in the output register while the next sample is taken.
// Reset clears state, pointer, sample count and sums; history RAM is not cleared
// (no clearing pass), its stale entries are masked by the sample count.
module trapezoidal_pulse_shaper_core #(
  parameter int unsigned HistoryDepth = tps_pkg::HISTORY_DEPTH,
  parameter int unsigned MaxRise      = tps_pkg::MAX_RISE,
  parameter int unsigned SampleBits   = tps_pkg::SAMPLE_BITS
) (
  input logic        clk_i,
  input logic        rst_ni,
  tps_in_if.sink     in_chan,
  tps_out_if.source  out_chan,
  tps_cfg_if.sink    cfg_chan
);

  localparam int unsigned AddrW = $clog2(HistoryDepth);

  logic [tps_pkg::DECAY_W-1:0] decay_q;
  logic [tps_pkg::RISE_W-1:0]  rise_q;
  logic [tps_pkg::FLAT_W-1:0]  flat_q;
  logic [tps_pkg::GAIN_W-1:0]  gain_q;

  tps_pkg::tps_ctrl_t  ctrl;
  logic                out_free;
  logic                ram_we;
  logic [AddrW-1:0]    ram_waddr, ram_raddr;
  logic [SampleBits-1:0] ram_wdata, ram_rdata;

  // Take configuration writes at any time, ignore unknown indexes
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q <= tps_pkg::DECAY_RST;
      rise_q  <= tps_pkg::RISE_RST;
      flat_q  <= tps_pkg::FLAT_RST;
      gain_q  <= tps_pkg::GAIN_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        tps_pkg::CFG_IDX_DECAY: decay_q <= cfg_chan.data[tps_pkg::DECAY_W-1:0];
        tps_pkg::CFG_IDX_RISE:  rise_q  <= cfg_chan.data[tps_pkg::RISE_W-1:0];
        tps_pkg::CFG_IDX_FLAT:  flat_q  <= cfg_chan.data[tps_pkg::FLAT_W-1:0];
        tps_pkg::CFG_IDX_GAIN:  gain_q  <= cfg_chan.data[tps_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  tps_seq #(
    .HistoryDepth (HistoryDepth),
    .MaxRise      (MaxRise)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_chan.valid),
    .in_first_i  (in_chan.first_sample),
    .out_free_i  (out_free),
    .rise_i      (rise_q),
    .flat_i      (flat_q),
    .in_ready_o  (in_chan.ready),
    .ctrl_o      (ctrl),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_raddr_o (ram_raddr)
  );

  tps_ram #(
    .Width (SampleBits),
    .Depth (HistoryDepth)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tps_datapath #(
    .SampleBits (SampleBits)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .in_sample_i  (in_chan.sample),
    .ram_rdata_i  (ram_rdata),
    .decay_i      (decay_q),
    .gain_i       (gain_q),
    .out_ready_i  (out_chan.ready),
    .ram_wdata_o  (ram_wdata),
    .out_valid_o  (out_chan.valid),
    .out_shaped_o (out_chan.shaped),
    .out_free_o   (out_free)
  );

endmodule

[rtl/core/tps_checker.sv]
// Port-level checker of the trapezoidal pulse shaper and its bind.
`include "trapezoidal_pulse_shaper_core_macros.svh"

module tps_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [tps_pkg::SHAPED_W-1:0] out_shaped_i
);

  logic in_acc;
  logic out_stall;

  assign in_acc    = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  // Hold a stalled result
  `TPS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable(out_shaped_i))
  // Drop ready while an accepted sample is in work
  `TPS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, !in_ready_i)
  // Never present a result in the cycle right after a sample is taken into an empty slot
  `TPS_ASSERT_NEXT(a_no_early_result, clk_i, rst_ni, in_acc && !out_valid_i, !out_valid_i)
  // Present only fully known result values
  `TPS_ASSERT_SAME(a_result_known, clk_i, rst_ni, out_valid_i, !$isunknown(out_shaped_i))

endmodule

bind trapezoidal_pulse_shaper_core tps_checker u_tps_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_chan.valid),
  .in_ready_i   (in_chan.ready),
  .out_valid_i  (out_chan.valid),
  .out_ready_i  (out_chan.ready),
  .out_shaped_i (out_chan.shaped)
);

[test/tb_trapezoidal_pulse_shaper_core.sv]
// Testbench of the trapezoidal pulse shaper core: directed and random waveforms checked against a predictor.
module tb_trapezoidal_pulse_shaper_core;
  import tps_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned END_CYCLES   = 20;
  localparam int unsigned RANDOM_ITEMS = 1300;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = SAMPLE_BITS'((1 << (SAMPLE_BITS-1)) - 1);
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = SAMPLE_BITS'(1 << (SAMPLE_BITS-1));
  localparam logic [GAIN_W-1:0]             GAIN_UNITY = GAIN_W'(1) << GAIN_FRAC;
  localparam logic [CFG_IDX_W-1:0]          CFG_IDX_SPARE = '1;

  localparam logic signed [79:0] SHAPED_TOP    = 80'sd2147483647;
  localparam logic signed [79:0] SHAPED_BOTTOM = -80'sd2147483648;

  // Predicts the shaped output of every accepted sample and checks results in order
  class shaper_scoreboard;
    logic signed [SAMPLE_BITS-1:0] past [HISTORY_DEPTH];
    int unsigned                   wr_ptr;
    int unsigned                   seen;
    logic [INNER_W-1:0]            inner;
    logic [OUTER_W-1:0]            outer;
    logic [DECAY_W-1:0]            decay;
    logic [RISE_W-1:0]             rise;
    logic [FLAT_W-1:0]             flat;
    logic [GAIN_W-1:0]             gain;
    logic signed [SHAPED_W-1:0]    shaped_due [$];
    int                            errors;

    function new();
      decay  = DECAY_RST;
      rise   = RISE_RST;
      flat   = FLAT_RST;
      gain   = GAIN_RST;
      wr_ptr = 0;
      seen   = 0;
      inner  = '0;
      outer  = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_IDX_DECAY: decay = data[DECAY_W-1:0];
        CFG_IDX_RISE:  rise  = data[RISE_W-1:0];
        CFG_IDX_FLAT:  flat  = data[FLAT_W-1:0];
        CFG_IDX_GAIN:  gain  = data[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    // Read a delayed sample; taps older than the waveform or the history read zero
    function longint delayed(int unsigned dly, longint cur);
      if (dly == 0) return cur;
      if (dly > seen || dly > HISTORY_DEPTH) return 0;
      return longint'(past[(wr_ptr + HISTORY_DEPTH - dly) % HISTORY_DEPTH]);
    endfunction

    function void note_sample(logic signed [SAMPLE_BITS-1:0] value, bit first);
      longint                      x;
      longint                      d;
      int unsigned                 k;
      int unsigned                 l;
      logic signed [79:0]          wide_outer;
      logic signed [79:0]          wide_gain;
      logic signed [79:0]          prod;
      logic signed [SHAPED_W-1:0]  shaped;
      if (first) begin
        wr_ptr = 0;
        seen   = 0;
        inner  = '0;
        outer  = '0;
      end
      x = value;
      k = (rise > MAX_RISE) ? MAX_RISE : rise;
      l = k + flat;
      d = x - delayed(k, x) - delayed(l, x) + delayed(k + l, x);

      // Advance both accumulators with their natural wrap
      inner = inner + INNER_W'(d);
      outer = outer + {{(OUTER_W-INNER_W){inner[INNER_W-1]}}, inner}
                    + OUTER_W'(longint'(decay) * d);

      past[wr_ptr] = value;
      wr_ptr = (wr_ptr + 1) % HISTORY_DEPTH;
      if (seen < HISTORY_DEPTH) seen++;

      // Scale by the Q1.24 gain, floor the shift, clamp to 32 bits
      wide_outer = {{(80-OUTER_W){outer[OUTER_W-1]}}, outer};
      wide_gain  = {{(80-GAIN_W){1'b0}}, gain};
      prod = (wide_outer * wide_gain) >>> GAIN_FRAC;
      if (prod > SHAPED_TOP) prod = SHAPED_TOP;
      if (prod < SHAPED_BOTTOM) prod = SHAPED_BOTTOM;
      shaped = prod[SHAPED_W-1:0];
      shaped_due.push_back(shaped);
    endfunction

    function void check_shaped(logic signed [SHAPED_W-1:0] got);
      logic signed [SHAPED_W-1:0] want;
      if (shaped_due.size() == 0) begin
        $display("%0t: shaped %0d arrived with nothing expected", $time, got);
        errors++;
        return;
      end
      want = shaped_due.pop_front();
      if (got !== want) begin
        $display("%0t: shaped mismatch, expected %0d got %0d", $time, want, got);
        errors++;
      end
    endfunction

    function int pending();
      return shaped_due.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  tps_in_if  in_if ();
  tps_out_if out_if ();
  tps_cfg_if cfg_if ();

  trapezoidal_pulse_shaper_core u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  shaper_scoreboard sb;
  bit               idle_on;
  bit               hold_req;
  int unsigned      random_items;
  int unsigned      stall_cycles;

  always #5 clk_i = ~clk_i;

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2, 3: return SAMPLE_BITS'(int'($urandom_range(0, 1023)) - 512);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] small_noise();
    return SAMPLE_BITS'(int'($urandom_range(0, 63)) - 32);
  endfunction

  // Offer one sample request after a random gap; valid stays high after acceptance
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value, input bit first);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.sample       <= value;
    in_if.first_sample <= first;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_sample(value, first);
  endtask

  // Drop the sample request and wait until every shaped value is back
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_reg(idx, data);
  endtask

  task automatic program_regs(input logic [DECAY_W-1:0] m, input logic [RISE_W-1:0] k,
                              input logic [FLAT_W-1:0] f, input logic [GAIN_W-1:0] g);
    write_reg(CFG_IDX_DECAY, CFG_DATA_W'(m));
    write_reg(CFG_IDX_RISE, CFG_DATA_W'(k));
    write_reg(CFG_IDX_FLAT, CFG_DATA_W'(f));
    write_reg(CFG_IDX_GAIN, CFG_DATA_W'(g));
    cfg_if.valid <= 1'b0;
  endtask

  // Draw a setting, mostly short taps with a matching gain, sometimes the extremes
  task automatic program_random();
    logic [DECAY_W-1:0] m;
    logic [RISE_W-1:0]  k;
    logic [FLAT_W-1:0]  f;
    logic [GAIN_W-1:0]  g;
    int unsigned        k_eff;
    case ($urandom_range(0, 9))
      0: k = '0;
      1: k = RISE_W'(MAX_RISE);
      2: k = RISE_W'($urandom_range(MAX_RISE + 1, (1 << RISE_W) - 1));
      3: k = RISE_W'($urandom);
      default: k = RISE_W'($urandom_range(1, 12));
    endcase
    case ($urandom_range(0, 9))
      0: f = '0;
      1: f = FLAT_W'(1024);
      2: f = FLAT_W'($urandom_range(1025, (1 << FLAT_W) - 1));
      3: f = FLAT_W'($urandom);
      default: f = FLAT_W'($urandom_range(0, 12));
    endcase
    case ($urandom_range(0, 9))
      0: m = '0;
      1: m = DECAY_W'(1);
      2: m = '1;
      3: m = DECAY_W'($urandom);
      default: m = DECAY_W'($urandom_range(1, 2000));
    endcase
    k_eff = (k > MAX_RISE) ? MAX_RISE : k;
    case ($urandom_range(0, 9))
      0: g = '0;
      1: g = '1;
      2: g = GAIN_UNITY;
      3: g = GAIN_W'($urandom);
      default: g = (m * k_eff != 0) ? GAIN_W'(GAIN_UNITY / (m * k_eff)) : GAIN_UNITY;
    endcase
    program_regs(m, k, f, g);
  endtask

  // Send one waveform: a step pulse on noise or free samples; broken ones restart at random
  task automatic run_waveform(input int unsigned len, input bit broken);
    int unsigned                   onset;
    bit                            pulse;
    bit                            first;
    logic signed [SAMPLE_BITS-1:0] amp;
    logic signed [SAMPLE_BITS-1:0] value;
    pulse = $urandom_range(0, 1);
    onset = $urandom_range(0, len - 1);
    amp   = pick_sample();
    for (int unsigned n = 0; n < len; n++) begin
      if (pulse) value = (n >= onset) ? amp : small_noise();
      else value = pick_sample();
      first = broken ? ($urandom_range(0, 7) == 0) : (n == 0);
      send_sample(value, first);
      random_items++;
    end
  endtask

  // Take shaped results with random stalls and one long hold-off on request
  initial begin
    int unsigned gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      gap = idle_on ? $urandom_range(0, 15) : 0;
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      sb.check_shaped(out_if.shaped);
    end
  end

  // End the run when no request moves on any channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL trapezoidal_pulse_shaper_core");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned phase;
    int unsigned waves;
    int unsigned len;
    bit          broken;
    sb                 = new();
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.sample       = '0;
    in_if.first_sample = 1'b0;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    idle_on            = 1'b1;
    hold_req           = 1'b0;
    random_items       = 0;
    stall_cycles       = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings, no waveform start: taps are masked by the empty history
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample('0, 1'b0);
    settle();

    // Short taps at unity gain: walk the taps in from before the waveform start
    program_regs(DECAY_W'(3), RISE_W'(2), FLAT_W'(1), GAIN_UNITY);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_BITS'(1), 1'b0);
    send_sample(SAMPLE_BITS'(-1), 1'b0);
    send_sample('0, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    settle();

    // Zero rise and zero decay
    program_regs('0, '0, FLAT_W'(3), GAIN_UNITY);
    send_sample(SAMPLE_BITS'(100), 1'b1);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    settle();

    // Rise above the cap, taps past the history, gain above one: saturate both ways
    write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom));
    program_regs('1, '1, '1, '1);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    settle();

    // Zero gain
    program_regs(DECAY_W'(1000), RISE_W'(4), FLAT_W'(2), '0);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MIN, 1'b0);
    settle();

    // Random settings and waveforms; the first phase holds off the output side
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      program_random();
      idle_on = ($urandom_range(0, 3) != 0);
      broken  = ($urandom_range(0, 5) == 0);
      if (phase == 0) begin
        idle_on  = 1'b0;
        broken   = 1'b0;
        hold_req = 1'b1;
      end
      waves = $urandom_range(1, 4);
      repeat (waves) begin
        if (phase == 0) len = 30;
        else if ($urandom_range(0, 7) == 0) len = $urandom_range(40, 160);
        else len = $urandom_range(2, 40);
        run_waveform(len, broken);
      end
      settle();
      phase++;
    end

    repeat (END_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS trapezoidal_pulse_shaper_core");
    end else begin
      $display("FAIL trapezoidal_pulse_shaper_core");
    end
    $finish;
  end

endmodule
